FILE: src/rcfd_pkg.sv
// Shared types and constants for the RC channel frame decoder.
// Used by every module under src but rcfd_frame_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rcfd_pkg;

  localparam int FRAME_BYTES   = 32;
  localparam int CHANNEL_COUNT = 14;

  localparam logic [7:0]  HDR_FIRST  = 8'h20;
  localparam logic [7:0]  HDR_SECOND = 8'h40;
  localparam logic [15:0] SUM_BASE   = 16'hFFFF;

  localparam int WORDS_IN_FRAME = (FRAME_BYTES - 4) / 2;
  localparam int EMIT_COUNT =
    (CHANNEL_COUNT < WORDS_IN_FRAME) ? CHANNEL_COUNT : WORDS_IN_FRAME;

  // byte position within a frame, and the word address of the frame store
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int WORD_DEPTH  = (FRAME_BYTES + 1) / 2;
  localparam int WADDR_W     = POS_W - 1;

  // channel index counter
  localparam int CH_W = (EMIT_COUNT > 1) ? $clog2(EMIT_COUNT) : 1;

  // bytes that carry channel words
  localparam int CH_FIRST_BYTE = 2;
  localparam int CH_LAST_BYTE  = 2 * EMIT_COUNT + 1;

  typedef struct packed {
    logic go;        // good frame completed this cycle
    logic failsafe;  // all channel words zero or all 0xFFFF
  } frame_evt_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_READ,
    E_SHOW
  } emit_state_t;

endpackage

`default_nettype wire

FILE: src/rcfd_frame_ram.sv
// Simple dual-port frame store: one write port, one registered read port.
// Generic; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module rcfd_frame_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/rcfd_collect.sv
// Byte collector: header hunt, frame position, running sum, failsafe flags,
// word writes into the frame store and the checksum test. Uses rcfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcfd_collect (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      in_rx_byte,
  input  wire logic                            idle,
  output logic                                 wr_en,
  output logic      [rcfd_pkg::WADDR_W-1:0]    wr_addr,
  output logic      [15:0]                     wr_data,
  output rcfd_pkg::frame_evt_t                 evt
);

  logic [rcfd_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]                sum_r, sum_nxt;
  logic [7:0]                 lo_r, lo_nxt;
  logic                       zero_r, zero_nxt;
  logic                       ff_r, ff_nxt;
  logic                       take;
  logic [15:0]                expect_sum;

  assign in_ready   = idle;
  assign take       = in_valid & idle;
  assign expect_sum = rcfd_pkg::SUM_BASE - sum_r;

  assign wr_addr = pos_r[rcfd_pkg::POS_W-1:1];
  assign wr_data = {in_rx_byte, lo_r};

  always_comb begin
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    lo_nxt       = lo_r;
    zero_nxt     = zero_r;
    ff_nxt       = ff_r;
    wr_en        = 1'b0;
    evt.go       = 1'b0;
    evt.failsafe = zero_r | ff_r;
    if (take) begin
      lo_nxt = in_rx_byte;
      if (pos_r == '0) begin
        // hunt for the first header byte, drop anything else
        if (in_rx_byte == rcfd_pkg::HDR_FIRST) begin
          pos_nxt  = rcfd_pkg::POS_W'(1);
          sum_nxt  = {8'h00, in_rx_byte};
          zero_nxt = 1'b1;
          ff_nxt   = 1'b1;
        end
      end else if (pos_r == rcfd_pkg::POS_W'(1) && in_rx_byte != rcfd_pkg::HDR_SECOND) begin
        pos_nxt = '0;
        sum_nxt = '0;
      end else begin
        if (pos_r < rcfd_pkg::POS_W'(rcfd_pkg::FRAME_BYTES - 2)) begin
          sum_nxt = sum_r + {8'h00, in_rx_byte};
        end
        // odd position completes a word
        wr_en = pos_r[0];
        if (pos_r >= rcfd_pkg::POS_W'(rcfd_pkg::CH_FIRST_BYTE) &&
            pos_r <= rcfd_pkg::POS_W'(rcfd_pkg::CH_LAST_BYTE)) begin
          zero_nxt = zero_r & (in_rx_byte == 8'h00);
          ff_nxt   = ff_r & (in_rx_byte == 8'hFF);
        end
        if (pos_r == rcfd_pkg::POS_W'(rcfd_pkg::FRAME_BYTES - 1)) begin
          pos_nxt = '0;
          sum_nxt = '0;
          evt.go  = (expect_sum == {in_rx_byte, lo_r});
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    zero_r <= zero_nxt;
    ff_r   <= ff_nxt;
  end

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= rcfd_pkg::POS_W'(rcfd_pkg::FRAME_BYTES - 1))
    else $error("frame position out of range");

  a_go_restart: assert property (@(posedge clk) disable iff (!rst_n)
    evt.go |=> pos_r == '0 && sum_r == '0)
    else $error("frame end did not restart the hunt");

  a_no_write_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> take && pos_r != '0)
    else $error("store written outside a frame");
`endif

endmodule

`default_nettype wire

FILE: src/rcfd_emit.sv
// Result sequencer: reads channel words from the frame store after a good
// frame and presents one result per channel. Uses rcfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcfd_emit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rcfd_pkg::frame_evt_t         evt,
  output logic                              idle,
  output logic                              rd_en,
  output logic      [rcfd_pkg::WADDR_W-1:0] rd_addr,
  input  wire logic [15:0]                  rd_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [3:0]                   out_channel_number,
  output logic      [15:0]                  out_channel_value,
  output logic                              out_failsafe,
  output logic                              out_last
);

  rcfd_pkg::emit_state_t state_r, state_nxt;

  logic [rcfd_pkg::CH_W-1:0]   rd_k_r;
  logic [rcfd_pkg::CH_W-1:0]   out_num_r;
  logic                        fs_r;
  logic                        is_last;
  logic [rcfd_pkg::CH_W+3:0]   num_ext;

  assign is_last = (out_num_r == rcfd_pkg::CH_W'(rcfd_pkg::EMIT_COUNT - 1));
  assign num_ext = {4'b0000, out_num_r};

  // channel k sits in word k+1, after the header word
  assign rd_addr = rcfd_pkg::WADDR_W'(rd_k_r) + 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rcfd_pkg::E_IDLE: begin
        if (evt.go) begin
          state_nxt = rcfd_pkg::E_READ;
        end
      end
      rcfd_pkg::E_READ: begin
        state_nxt = rcfd_pkg::E_SHOW;
      end
      rcfd_pkg::E_SHOW: begin
        if (out_ready && is_last) begin
          state_nxt = rcfd_pkg::E_IDLE;
        end
      end
      default: begin
        state_nxt = rcfd_pkg::E_IDLE;
      end
    endcase
  end

  always_comb begin
    idle      = 1'b0;
    rd_en     = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      rcfd_pkg::E_IDLE: begin
        idle = 1'b1;
      end
      rcfd_pkg::E_READ: begin
        rd_en = 1'b1;
      end
      rcfd_pkg::E_SHOW: begin
        out_valid = 1'b1;
        // fetch the next word as the current result leaves
        rd_en     = out_ready & ~is_last;
      end
      default: begin
        idle = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcfd_pkg::E_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (idle && evt.go) begin
      rd_k_r <= '0;
      fs_r   <= evt.failsafe;
    end else if (rd_en) begin
      rd_k_r    <= rd_k_r + 1'b1;
      out_num_r <= rd_k_r;
    end
  end

  assign out_channel_number = num_ext[3:0];
  assign out_channel_value  = rd_data;
  assign out_failsafe       = fs_r;
  assign out_last           = is_last;

`ifndef ASSERT_OFF
  a_go_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    evt.go |-> state_r == rcfd_pkg::E_IDLE)
    else $error("frame completed while results still pending");

  a_num_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rcfd_pkg::E_SHOW |->
      out_num_r <= rcfd_pkg::CH_W'(rcfd_pkg::EMIT_COUNT - 1))
    else $error("channel index past the last channel");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      state_r == rcfd_pkg::E_SHOW &&
      out_num_r == rcfd_pkg::CH_W'($past(out_num_r) + 1'b1))
    else $error("channel sequence skipped or stalled");

  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> state_r == rcfd_pkg::E_IDLE)
    else $error("sequencer did not return to idle after last channel");
`endif

endmodule

`default_nettype wire

FILE: src/rc_channel_frame_decoder_core.sv
// Top level of the RC channel frame decoder: byte collector, frame store
// and result sequencer. Uses rcfd_pkg, rcfd_collect, rcfd_frame_ram, rcfd_emit.
//
//   channel   ports                                     dir   carries
//   input     in_valid/in_ready, in_rx_byte            in    one serial byte
//   result    out_valid/out_ready, out_channel_number,  out   one channel word
//             out_channel_value, out_failsafe, out_last
//
// Collecting: one byte per cycle while the sequencer is idle; each odd byte writes a
// 16-bit word to the store. After a good frame the input is held off while the
// sequencer reads the store: first the read of channel 0, then one result per cycle
// while out_ready is high, until the last channel is taken and it returns to idle.
// A stalled result holds its word in the store's read register.
// Reset (rst_n low, synchronous) clears position, sum and sequencer; the frame
// store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module rc_channel_frame_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [3:0]  out_channel_number,
  output logic      [15:0] out_channel_value,
  output logic             out_failsafe,
  output logic             out_last
);

  rcfd_pkg::frame_evt_t           evt;
  logic                           idle;
  logic                           wr_en;
  logic [rcfd_pkg::WADDR_W-1:0]   wr_addr;
  logic [15:0]                    wr_data;
  logic                           rd_en;
  logic [rcfd_pkg::WADDR_W-1:0]   rd_addr;
  logic [15:0]                    rd_data;

  rcfd_collect u_collect (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .idle       (idle),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .evt        (evt)
  );

  rcfd_frame_ram #(
    .DEPTH (rcfd_pkg::WORD_DEPTH),
    .WIDTH (16),
    .AW    (rcfd_pkg::WADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rcfd_emit u_emit (
    .clk                (clk),
    .rst_n              (rst_n),
    .evt                (evt),
    .idle               (idle),
    .rd_en              (rd_en),
    .rd_addr            (rd_addr),
    .rd_data            (rd_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_channel_number (out_channel_number),
    .out_channel_value  (out_channel_value),
    .out_failsafe       (out_failsafe),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire

FILE: tb/rc_channel_frame_decoder_core_tb.sv
// Self-checking testbench for rc_channel_frame_decoder_core: byte stream in, channel words out.
// Depends on rcfd_pkg for frame sizes and header constants. Has its own frame decoder
// model that predicts the channel results.
`timescale 1ns / 1ps

module rc_channel_frame_decoder_core_tb;

  localparam int ITEMS_TARGET = 170;

  typedef struct {
    logic [7:0] data;
    bit         drain;   // hold this request until all channel words are out
  } rx_req_t;

  typedef struct {
    logic [3:0]  num;
    logic [15:0] value;
    logic        failsafe;
    logic        last;
  } chan_word_t;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES,
    FILL_SPARSE,
    FILL_DENT
  } fill_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_channel_number;
  logic [15:0] out_channel_value;
  logic        out_failsafe;
  logic        out_last;

  rx_req_t    byte_backlog [$];
  chan_word_t chan_expect [$];

  // decoder model state
  logic [7:0]  seen_bytes [rcfd_pkg::FRAME_BYTES];
  int unsigned seen_pos = 0;
  logic [15:0] seen_sum = '0;

  bit byte_taken = 1'b0;
  int bytes_accepted = 0;
  int words_seen = 0;
  int frames_out = 0;
  int mismatches = 0;

  rc_channel_frame_decoder_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_channel_number (out_channel_number),
    .out_channel_value  (out_channel_value),
    .out_failsafe       (out_failsafe),
    .out_last           (out_last)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Advance the frame model by one accepted byte; queue channel words on a good frame.
  task automatic absorb_byte(input logic [7:0] b);
    logic [15:0] want_sum;
    logic [15:0] sent_sum;
    logic [15:0] w;
    bit          words_zero;
    bit          all_ones;
    chan_word_t  cw;
    if (seen_pos == 0 && b != rcfd_pkg::HDR_FIRST) return;
    if (seen_pos == 1 && b != rcfd_pkg::HDR_SECOND) begin
      seen_pos = 0;
      seen_sum = '0;
      return;
    end
    if (seen_pos == 0) seen_sum = '0;
    seen_bytes[seen_pos] = b;
    if (seen_pos < rcfd_pkg::FRAME_BYTES - 2) seen_sum = seen_sum + 16'(b);
    seen_pos++;
    if (seen_pos < rcfd_pkg::FRAME_BYTES) return;
    seen_pos = 0;
    want_sum = rcfd_pkg::SUM_BASE - seen_sum;
    sent_sum = {seen_bytes[rcfd_pkg::FRAME_BYTES-1], seen_bytes[rcfd_pkg::FRAME_BYTES-2]};
    seen_sum = '0;
    if (want_sum != sent_sum) return;
    words_zero = 1'b1;
    all_ones   = 1'b1;
    for (int k = 0; k < rcfd_pkg::EMIT_COUNT; k++) begin
      w = {seen_bytes[3+2*k], seen_bytes[2+2*k]};
      if (w != 16'h0000) words_zero = 1'b0;
      if (w != 16'hFFFF) all_ones = 1'b0;
    end
    for (int k = 0; k < rcfd_pkg::EMIT_COUNT; k++) begin
      cw.num      = 4'(k);
      cw.value    = {seen_bytes[3+2*k], seen_bytes[2+2*k]};
      cw.failsafe = words_zero || all_ones;
      cw.last     = (k == rcfd_pkg::EMIT_COUNT - 1);
      chan_expect.push_back(cw);
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    rx_req_t r;
    r.data  = b;
    r.drain = 1'b0;
    byte_backlog.push_back(r);
  endtask

  // Build one full frame with a correct or corrupted trailing checksum.
  task automatic queue_frame(input fill_t fill, input bit bad_sum, input bit drain);
    logic [7:0]  fb [rcfd_pkg::FRAME_BYTES];
    logic [15:0] sum;
    rx_req_t     r;
    int          hot;
    hot = $urandom_range(2, rcfd_pkg::FRAME_BYTES - 3);
    fb[0] = rcfd_pkg::HDR_FIRST;
    fb[1] = rcfd_pkg::HDR_SECOND;
    for (int i = 2; i < rcfd_pkg::FRAME_BYTES - 2; i++) begin
      case (fill)
        FILL_ZERO:   fb[i] = 8'h00;
        FILL_ONES:   fb[i] = 8'hFF;
        FILL_SPARSE: fb[i] = (i == hot) ? 8'($urandom_range(1, 255)) : 8'h00;
        FILL_DENT:   fb[i] = (i == hot) ? 8'($urandom_range(0, 254)) : 8'hFF;
        default:     fb[i] = 8'($urandom_range(0, 255));
      endcase
    end
    sum = '0;
    for (int i = 0; i < rcfd_pkg::FRAME_BYTES - 2; i++) sum = sum + 16'(fb[i]);
    sum = rcfd_pkg::SUM_BASE - sum;
    if (bad_sum) sum = sum ^ (16'h0001 << $urandom_range(0, 15));
    fb[rcfd_pkg::FRAME_BYTES-2] = sum[7:0];
    fb[rcfd_pkg::FRAME_BYTES-1] = sum[15:8];
    for (int i = 0; i < rcfd_pkg::FRAME_BYTES; i++) begin
      r.data  = fb[i];
      r.drain = drain && (i == 0);
      byte_backlog.push_back(r);
    end
  endtask

  // Sample both handshakes at the rising edge.
  always @(posedge clk) begin
    chan_word_t cw;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        absorb_byte(in_rx_byte);
        byte_taken = 1'b1;
        bytes_accepted++;
      end
      if (out_valid && out_ready) begin
        words_seen++;
        if (out_last) frames_out++;
        if (chan_expect.size() == 0) begin
          report_mismatch("unexpected channel_value", out_channel_value, 0);
        end else begin
          cw = chan_expect.pop_front();
          if (out_channel_number !== cw.num)
            report_mismatch("channel_number", out_channel_number, cw.num);
          if (out_channel_value !== cw.value)
            report_mismatch("channel_value", out_channel_value, cw.value);
          if (out_failsafe !== cw.failsafe)
            report_mismatch("failsafe", out_failsafe, cw.failsafe);
          if (out_last !== cw.last)
            report_mismatch("last", out_last, cw.last);
        end
      end
    end
  end

  // Request driver: hold a pending request until taken, then pick the next one.
  always @(negedge clk) begin
    bit calm;
    bit next_valid;
    calm = (bytes_accepted >= 100) && (bytes_accepted < 180);
    next_valid = in_valid;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (!in_valid || byte_taken) begin
      byte_taken = 1'b0;
      next_valid = 1'b0;
      if (byte_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 20) &&
          !(byte_backlog[0].drain && chan_expect.size() != 0)) begin
        in_rx_byte <= byte_backlog[0].data;
        void'(byte_backlog.pop_front());
        next_valid = 1'b1;
      end
    end
    in_valid <= next_valid;
  end

  // Result stalls, with a calm stretch in the middle of the run.
  always @(negedge clk) begin
    out_ready <= (words_seen >= 20 && words_seen < 56) || ($urandom_range(0, 99) >= 20);
  end

  initial begin
    int    pick;
    logic [7:0] b;

    // hunting: drop non-header bytes, a second 0x20 is no new header
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(rcfd_pkg::HDR_SECOND);
    push_byte(rcfd_pkg::HDR_FIRST);
    push_byte(rcfd_pkg::HDR_FIRST);
    push_byte(rcfd_pkg::HDR_SECOND);
    push_byte(rcfd_pkg::HDR_FIRST);
    push_byte(8'h41);
    queue_frame(FILL_ZERO, 1'b0, 1'b0);
    queue_frame(FILL_ONES, 1'b0, 1'b1);
    queue_frame(FILL_RANDOM, 1'b1, 1'b0);
    queue_frame(FILL_DENT, 1'b0, 1'b0);

    while (byte_backlog.size() < ITEMS_TARGET) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          do b = 8'($urandom_range(0, 255)); while (b == rcfd_pkg::HDR_FIRST);
          push_byte(b);
        end
        1: begin
          do b = 8'($urandom_range(0, 255)); while (b == rcfd_pkg::HDR_SECOND);
          push_byte(rcfd_pkg::HDR_FIRST);
          push_byte(b);
        end
        2: begin
          queue_frame(FILL_RANDOM, 1'b1, $urandom_range(0, 3) == 0);
        end
        3: begin
          queue_frame(fill_t'($urandom_range(FILL_ZERO, FILL_DENT)), 1'b0,
                      $urandom_range(0, 3) == 0);
        end
        default: begin
          queue_frame($urandom_range(0, 3) == 0 ? FILL_SPARSE : FILL_RANDOM, 1'b0,
                      $urandom_range(0, 3) == 0);
        end
      endcase
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (byte_backlog.size() != 0 || in_valid) @(posedge clk);
    while (chan_expect.size() != 0) @(posedge clk);
    // let any stray result surface before closing
    repeat (rcfd_pkg::EMIT_COUNT + 8) @(posedge clk);

    $display("Sent %0d bytes: header hunting, bad second header, bad checksums, failsafe frames.",
             bytes_accepted);
    $display("Checked %0d channel words from %0d good frames, %0d mismatches.",
             words_seen, frames_out, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d requests pending and %0d words expected",
             byte_backlog.size(), chan_expect.size());
    $display("Verification failed");
    $finish;
  end

endmodule
